// ===== rtl/core/dual_queue_priority_runway_scheduler_defines.svh =====
// Assertion macros shared by the scheduler modules.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef DUAL_QUEUE_PRIORITY_RUNWAY_SCHEDULER_DEFINES_SVH
`define DUAL_QUEUE_PRIORITY_RUNWAY_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DQPRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define DQPRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dqprs_pkg.sv =====
// Shared types and constants for the two-queue priority scheduler.
// No dependencies.
package dqprs_pkg;

	// Wide enough for a fill count at the largest supported queue depth (64).
	localparam int unsigned LIM_W = 7;

	// Reset value of both capacity registers.
	localparam logic [3:0] CAP_RESET = 4'd5;

	// Register indexes on the configuration port.
	localparam logic REG_HIGH_CAP = 1'b0;
	localparam logic REG_LOW_CAP  = 1'b1;

	// Codes of the served_kind field.
	localparam logic [1:0] KIND_IDLE = 2'd0;
	localparam logic [1:0] KIND_HIGH = 2'd1;
	localparam logic [1:0] KIND_LOW  = 2'd2;

	// Per-tick control broadcast from a queue to each of its stamp cells.
	typedef struct packed {
		logic             en;
		logic             pop;
		logic [LIM_W-1:0] keep_lim;
		logic [LIM_W-1:0] fill_lim;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/dqprs_cell.sv =====
// One stamp cell of a queue chain: holds the arrival tick of one waiting request.
// Depends on dqprs_pkg.
module dqprs_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                clk,
	input  dqprs_pkg::cell_ctrl_t ctrl,
	input  logic [31:0]         tick,
	input  logic [31:0]         next_stamp,
	output logic [31:0]         stamp
);
	import dqprs_pkg::*;

	localparam logic [LIM_W-1:0] POS = LIM_W'(IDX);

	logic [31:0] stamp_q;

	// Surviving entries move one place toward the head on a pop; new arrivals
	// land just behind them with the current tick.
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			if (POS < ctrl.keep_lim) begin
				if (ctrl.pop) begin
					stamp_q <= next_stamp;
				end
			end else if (POS < ctrl.fill_lim) begin
				stamp_q <= tick;
			end
		end
	end

	assign stamp = stamp_q;

endmodule

// ===== rtl/core/dqprs_queue.sv =====
// One bounded FIFO of arrival stamps built as a chain of cells, with its fill count.
// Depends on dqprs_pkg and dqprs_cell.
`include "dual_queue_priority_runway_scheduler_defines.svh"
module dqprs_queue #(
	parameter int unsigned DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic [3:0]                        req_count,
	input  logic [3:0]                        cap_cfg,
	input  logic                              pop,
	input  logic [31:0]                       tick,
	output logic                              nonempty,
	output logic [31:0]                       head_wait,
	output logic [3:0]                        refused,
	output logic [$clog2(DEPTH+1)-1:0]        fill
);
	import dqprs_pkg::*;

	localparam int unsigned FW = $clog2(DEPTH + 1);
	localparam int unsigned AW = (FW > 4) ? FW : 4;

	logic [FW-1:0] fill_q;
	logic [FW-1:0] cap;
	logic [FW-1:0] room;
	logic [FW-1:0] acc;
	logic [FW-1:0] app_fill;
	logic [FW-1:0] keep;
	logic [31:0]   head_stamp;
	logic [31:0]   stamps [DEPTH];
	cell_ctrl_t    ctrl;

	// Effective capacity and the number of arrivals that still fit.
	always_comb begin
		cap      = (32'(cap_cfg) > DEPTH) ? FW'(DEPTH) : FW'(cap_cfg);
		room     = (cap > fill_q) ? (cap - fill_q) : '0;
		acc      = (AW'(req_count) < AW'(room)) ? FW'(req_count) : room;
		app_fill = fill_q + acc;
		keep     = pop ? ((fill_q != '0) ? (fill_q - FW'(1)) : '0) : fill_q;
	end

	assign nonempty = (app_fill != '0);
	assign refused  = req_count - 4'(acc);

	// Control shared by every cell of the chain.
	always_comb begin
		ctrl.en       = step;
		ctrl.pop      = pop;
		ctrl.keep_lim = LIM_W'(keep);
		ctrl.fill_lim = LIM_W'(app_fill - FW'(pop));
	end

	// The chain: on a pop, each surviving cell takes its neighbor's stamp.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [31:0] nb;
		if (i == DEPTH - 1) begin : g_last
			assign nb = tick;
		end else begin : g_mid
			assign nb = stamps[i+1];
		end
		dqprs_cell #(.IDX(i)) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.tick       (tick),
			.next_stamp (nb),
			.stamp      (stamps[i])
		);
	end

	// A request that arrives and leaves in the same tick waited zero ticks.
	assign head_stamp = (fill_q != '0) ? stamps[0] : tick;
	assign head_wait  = tick - head_stamp;

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (step) begin
			fill_q <= app_fill - FW'(pop);
		end
	end

	assign fill = fill_q;

	`DQPRS_ASSERT_NOW(a_fill_bound, 1'b1, 32'(fill_q) <= DEPTH, "queue fill above depth")
	`DQPRS_ASSERT_NOW(a_pop_nonempty, step && pop, nonempty, "pop from an empty queue")
	`DQPRS_ASSERT_NEXT(a_fill_cap, step && !pop, fill_q <= $past(cap) || fill_q == $past(fill_q),
		"fill grew past capacity")

endmodule

// ===== rtl/core/dqprs_stats.sv =====
// Saturating totals and wait sums of the scheduler.
// Depends on dqprs_pkg.
module dqprs_stats (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [4:0]  total_add,
	input  logic [4:0]  refused_add,
	input  logic [1:0]  kind,
	input  logic [31:0] wait_ticks,
	output logic [31:0] total_requests,
	output logic [31:0] high_served_count,
	output logic [31:0] low_served_count,
	output logic [31:0] refused_count,
	output logic [31:0] idle_count,
	output logic [31:0] high_wait_sum,
	output logic [31:0] low_wait_sum
);
	import dqprs_pkg::*;

	logic [31:0] total_q, hserv_q, lserv_q, refused_q, idle_q, hwait_q, lwait_q;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? '1 : s[31:0];
	endfunction

	// Each counter sticks at its maximum instead of wrapping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			hserv_q   <= '0;
			lserv_q   <= '0;
			refused_q <= '0;
			idle_q    <= '0;
			hwait_q   <= '0;
			lwait_q   <= '0;
		end else if (step) begin
			total_q   <= sat_add(total_q, 32'(total_add));
			refused_q <= sat_add(refused_q, 32'(refused_add));
			case (kind)
				KIND_HIGH: begin
					hserv_q <= sat_add(hserv_q, 32'd1);
					hwait_q <= sat_add(hwait_q, wait_ticks);
				end
				KIND_LOW: begin
					lserv_q <= sat_add(lserv_q, 32'd1);
					lwait_q <= sat_add(lwait_q, wait_ticks);
				end
				default: begin
					idle_q <= sat_add(idle_q, 32'd1);
				end
			endcase
		end
	end

	assign total_requests    = total_q;
	assign high_served_count = hserv_q;
	assign low_served_count  = lserv_q;
	assign refused_count     = refused_q;
	assign idle_count        = idle_q;
	assign high_wait_sum     = hwait_q;
	assign low_wait_sum      = lwait_q;

endmodule

// ===== rtl/core/dual_queue_priority_runway_scheduler.sv =====
// Strict-priority scheduler over two bounded stamp queues with saturating wait statistics.
// Each request is one tick; the result appears in a result register in the cycle after
// acceptance, and a new request is taken every cycle in which that register is free or
// being drained, so the block sustains one tick per clock. That rate is set by each
// queue's cell chain updating its fill and picking its head within each tick. Capacities are
// written over the configuration port at byte addresses 0 (high) and 4 (low).
// Depends on dqprs_pkg, dqprs_queue, dqprs_stats and the assertion macro header.
`include "dual_queue_priority_runway_scheduler_defines.svh"
module dual_queue_priority_runway_scheduler #(
	parameter int unsigned QUEUE_DEPTH  = 8,
	parameter int unsigned MAX_REQUESTS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Request channel
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [3:0]  high_requests,
	input  logic [3:0]  low_requests,
	// Result channel
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  served_kind,
	output logic [31:0] served_wait,
	output logic [31:0] total_requests,
	output logic [31:0] high_served_count,
	output logic [31:0] low_served_count,
	output logic [31:0] refused_count,
	output logic [31:0] idle_count,
	output logic [31:0] high_wait_sum,
	output logic [31:0] low_wait_sum,
	output logic [3:0]  high_occupancy,
	output logic [3:0]  low_occupancy
);
	import dqprs_pkg::*;

	localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

	logic [3:0]    high_cap_q, low_cap_q;
	logic [31:0]   tick_q;
	logic          res_valid_q;
	logic [1:0]    kind_q;
	logic [31:0]   wait_q;
	logic          step;
	logic [3:0]    hr, lr;
	logic          high_ne, low_ne, high_pop, low_pop;
	logic [31:0]   high_wait, low_wait;
	logic [3:0]    high_ref, low_ref;
	logic [FW-1:0] high_fill, low_fill;
	logic [1:0]    kind;
	logic [31:0]   wait_ticks;

	// Configuration registers.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_cap_q <= CAP_RESET;
			low_cap_q  <= CAP_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_HIGH_CAP: high_cap_q <= pwdata[3:0];
				REG_LOW_CAP:  low_cap_q  <= pwdata[3:0];
				default:      high_cap_q <= high_cap_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_HIGH_CAP: prdata = 32'(high_cap_q);
			REG_LOW_CAP:  prdata = 32'(low_cap_q);
			default:      prdata = '0;
		endcase
	end

	// A request is taken whenever the result register is free or drains this cycle.
	assign req_ready = !res_valid_q || res_ready;
	assign step      = req_valid && req_ready;

	// Clamp request counts.
	assign hr = (32'(high_requests) > MAX_REQUESTS) ? 4'(MAX_REQUESTS) : high_requests;
	assign lr = (32'(low_requests) > MAX_REQUESTS) ? 4'(MAX_REQUESTS) : low_requests;

	// High priority wins whenever its queue holds anything after arrivals.
	assign high_pop = high_ne;
	assign low_pop  = !high_ne && low_ne;

	dqprs_queue #(.DEPTH(QUEUE_DEPTH)) u_high (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.req_count (hr),
		.cap_cfg   (high_cap_q),
		.pop       (high_pop),
		.tick      (tick_q),
		.nonempty  (high_ne),
		.head_wait (high_wait),
		.refused   (high_ref),
		.fill      (high_fill)
	);

	dqprs_queue #(.DEPTH(QUEUE_DEPTH)) u_low (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.req_count (lr),
		.cap_cfg   (low_cap_q),
		.pop       (low_pop),
		.tick      (tick_q),
		.nonempty  (low_ne),
		.head_wait (low_wait),
		.refused   (low_ref),
		.fill      (low_fill)
	);

	// Served kind and wait for this tick.
	always_comb begin
		if (high_pop) begin
			kind       = KIND_HIGH;
			wait_ticks = high_wait;
		end else if (low_pop) begin
			kind       = KIND_LOW;
			wait_ticks = low_wait;
		end else begin
			kind       = KIND_IDLE;
			wait_ticks = '0;
		end
	end

	dqprs_stats u_stats (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (step),
		.total_add         (5'(hr) + 5'(lr)),
		.refused_add       (5'(high_ref) + 5'(low_ref)),
		.kind              (kind),
		.wait_ticks        (wait_ticks),
		.total_requests    (total_requests),
		.high_served_count (high_served_count),
		.low_served_count  (low_served_count),
		.refused_count     (refused_count),
		.idle_count        (idle_count),
		.high_wait_sum     (high_wait_sum),
		.low_wait_sum      (low_wait_sum)
	);

	// Tick counter and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (step) begin
				tick_q      <= tick_q + 32'd1;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			kind_q <= kind;
			wait_q <= wait_ticks;
		end
	end

	assign res_valid      = res_valid_q;
	assign served_kind    = kind_q;
	assign served_wait    = wait_q;
	assign high_occupancy = 4'(high_fill);
	assign low_occupancy  = 4'(low_fill);

	`DQPRS_ASSERT_NOW(a_idle_zero_wait, res_valid_q && kind_q == KIND_IDLE, wait_q == 32'd0,
		"idle tick reported a nonzero wait")
	`DQPRS_ASSERT_NEXT(a_high_first, step && high_fill != '0, kind_q == KIND_HIGH,
		"waiting high-priority request was not served first")
	`DQPRS_ASSERT_NOW(a_ready_when_empty, !res_valid_q, req_ready,
		"request refused while the result register is empty")

endmodule

// ===== sim/scheduler_report_checker.sv =====
// Report checker for the two-queue priority scheduler: watches the configuration port and
// both channels, predicts every tick report and compares it field by field.
// Depends on dqprs_pkg for the served-kind codes and the register indexes.
`timescale 1ns / 1ps
module scheduler_report_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        req_valid,
	input  logic        req_ready,
	input  logic [3:0]  high_requests,
	input  logic [3:0]  low_requests,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic [1:0]  served_kind,
	input  logic [31:0] served_wait,
	input  logic [31:0] total_requests,
	input  logic [31:0] high_served_count,
	input  logic [31:0] low_served_count,
	input  logic [31:0] refused_count,
	input  logic [31:0] idle_count,
	input  logic [31:0] high_wait_sum,
	input  logic [31:0] low_wait_sum,
	input  logic [3:0]  high_occupancy,
	input  logic [3:0]  low_occupancy,
	output int          reports_owed,
	output int          mismatches
);
	import dqprs_pkg::*;

	localparam int DEPTH = 8;
	localparam int HIGH = 0;
	localparam int LOW = 1;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] wait_ticks;
		logic [31:0] total;
		logic [31:0] high_served;
		logic [31:0] low_served;
		logic [31:0] refused;
		logic [31:0] idle;
		logic [31:0] high_wait;
		logic [31:0] low_wait;
		logic [3:0]  high_occ;
		logic [3:0]  low_occ;
	} tick_report_t;

	// Reports predicted for accepted requests, oldest first.
	tick_report_t pending_reports[$];

	// Predicted scheduler state, indexed by queue where there is one per queue.
	logic [3:0]  cap_reg[2];
	logic [31:0] tick_count;
	logic [31:0] stamp[2][DEPTH];
	int unsigned head[2];
	int unsigned fill[2];
	logic [31:0] total_seen;
	logic [31:0] refused_seen;
	logic [31:0] idle_seen;
	logic [31:0] served_seen[2];
	logic [31:0] wait_seen[2];

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Stamps the arrivals into queue q up to its usable size; returns how many bounced.
	function automatic logic [31:0] admit(int q, int unsigned n);
		int unsigned usable;
		logic [31:0] bounced;
		int i;
		usable = (cap_reg[q] > DEPTH) ? DEPTH : cap_reg[q];
		bounced = '0;
		for (i = 0; i < n; i++) begin
			if (fill[q] >= usable) begin
				bounced++;
			end else begin
				stamp[q][(head[q] + fill[q]) % DEPTH] = tick_count;
				fill[q]++;
			end
		end
		return bounced;
	endfunction

	// One tick: admit arrivals, serve the high head before the low head, update totals.
	// Request counts are 4 bits wide, so they never exceed the per-tick maximum of 15.
	function automatic tick_report_t schedule_tick(logic [3:0] high_n, logic [3:0] low_n);
		tick_report_t r;
		logic [31:0] age;
		int q;
		refused_seen = sat_add(refused_seen, admit(HIGH, high_n));
		refused_seen = sat_add(refused_seen, admit(LOW, low_n));
		total_seen = sat_add(total_seen, 32'(high_n) + 32'(low_n));
		age = '0;
		if (fill[HIGH] != 0 || fill[LOW] != 0) begin
			q = (fill[HIGH] != 0) ? HIGH : LOW;
			r.kind = (q == HIGH) ? KIND_HIGH : KIND_LOW;
			age = tick_count - stamp[q][head[q]];
			head[q] = (head[q] + 1) % DEPTH;
			fill[q]--;
			served_seen[q] = sat_add(served_seen[q], 32'd1);
			wait_seen[q] = sat_add(wait_seen[q], age);
		end else begin
			r.kind = KIND_IDLE;
			idle_seen = sat_add(idle_seen, 32'd1);
		end
		tick_count = tick_count + 32'd1;
		r.wait_ticks = age;
		r.total = total_seen;
		r.high_served = served_seen[HIGH];
		r.low_served = served_seen[LOW];
		r.refused = refused_seen;
		r.idle = idle_seen;
		r.high_wait = wait_seen[HIGH];
		r.low_wait = wait_seen[LOW];
		r.high_occ = 4'(fill[HIGH]);
		r.low_occ = 4'(fill[LOW]);
		return r;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Track register writes, check each accepted report, then predict each accepted request.
	// Reports are checked before the prediction of the same edge, since a report is always
	// registered and so trails its request.
	always @(posedge clk or negedge arst_n) begin
		tick_report_t want;
		int q;
		int i;
		if (!arst_n) begin
			for (q = 0; q < 2; q++) begin
				cap_reg[q] = CAP_RESET;
				head[q] = 0;
				fill[q] = 0;
				served_seen[q] = '0;
				wait_seen[q] = '0;
				for (i = 0; i < DEPTH; i++)
					stamp[q][i] = '0;
			end
			tick_count = '0;
			total_seen = '0;
			refused_seen = '0;
			idle_seen = '0;
			pending_reports.delete();
			mismatches = 0;
			reports_owed <= 0;
		end else begin
			if (psel && penable && pwrite && pready)
				cap_reg[(paddr[2] == REG_HIGH_CAP) ? HIGH : LOW] = pwdata[3:0];
			if (res_valid && res_ready) begin
				if (pending_reports.size() == 0) begin
					$error("report accepted with no request outstanding");
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					compare_field("served_kind", 32'(want.kind), 32'(served_kind));
					compare_field("served_wait", want.wait_ticks, served_wait);
					compare_field("total_requests", want.total, total_requests);
					compare_field("high_served_count", want.high_served, high_served_count);
					compare_field("low_served_count", want.low_served, low_served_count);
					compare_field("refused_count", want.refused, refused_count);
					compare_field("idle_count", want.idle, idle_count);
					compare_field("high_wait_sum", want.high_wait, high_wait_sum);
					compare_field("low_wait_sum", want.low_wait, low_wait_sum);
					compare_field("high_occupancy", 32'(want.high_occ), 32'(high_occupancy));
					compare_field("low_occupancy", 32'(want.low_occ), 32'(low_occupancy));
				end
			end
			if (req_valid && req_ready)
				pending_reports.push_back(schedule_tick(high_requests, low_requests));
			reports_owed <= pending_reports.size();
		end
	end

endmodule

// ===== sim/dual_queue_priority_runway_scheduler_test.sv =====
// Top of the scheduler testbench: clock, reset, capacity writes, tick requests and stalls.
// Depends on dqprs_pkg, the scheduler RTL and scheduler_report_checker.
`timescale 1ns / 1ps
module dual_queue_priority_runway_scheduler_test;
	import dqprs_pkg::*;

	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD = 60;
	localparam int QUIET_LIMIT = 1000;
	localparam int SEGMENTS = 12;
	localparam int SEGMENT_LEN = 104;

	// Capacity pair for each random segment; both registers see 0, 1, 8 and 15.
	localparam logic [3:0] HIGH_CAPS[SEGMENTS] = '{4'd5, 4'd1, 4'd8, 4'd0, 4'd15, 4'd2,
		4'd4, 4'd1, 4'd8, 4'd3, 4'd9, 4'd6};
	localparam logic [3:0] LOW_CAPS[SEGMENTS] = '{4'd5, 4'd1, 4'd8, 4'd3, 4'd9, 4'd0,
		4'd12, 4'd8, 4'd1, 4'd3, 4'd15, 4'd2};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [3:0]  high_requests = '0;
	logic [3:0]  low_requests = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [1:0]  served_kind;
	logic [31:0] served_wait;
	logic [31:0] total_requests;
	logic [31:0] high_served_count;
	logic [31:0] low_served_count;
	logic [31:0] refused_count;
	logic [31:0] idle_count;
	logic [31:0] high_wait_sum;
	logic [31:0] low_wait_sum;
	logic [3:0]  high_occupancy;
	logic [3:0]  low_occupancy;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_asked = 0;
	int hold_done = 0;
	int hold_left = 0;
	int reports_owed;
	int mismatches;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	dual_queue_priority_runway_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_ready(req_ready),
		.high_requests(high_requests), .low_requests(low_requests),
		.res_valid(res_valid), .res_ready(res_ready),
		.served_kind(served_kind), .served_wait(served_wait),
		.total_requests(total_requests), .high_served_count(high_served_count),
		.low_served_count(low_served_count), .refused_count(refused_count),
		.idle_count(idle_count), .high_wait_sum(high_wait_sum),
		.low_wait_sum(low_wait_sum), .high_occupancy(high_occupancy),
		.low_occupancy(low_occupancy)
	);

	scheduler_report_checker report_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.req_valid(req_valid), .req_ready(req_ready),
		.high_requests(high_requests), .low_requests(low_requests),
		.res_valid(res_valid), .res_ready(res_ready),
		.served_kind(served_kind), .served_wait(served_wait),
		.total_requests(total_requests), .high_served_count(high_served_count),
		.low_served_count(low_served_count), .refused_count(refused_count),
		.idle_count(idle_count), .high_wait_sum(high_wait_sum),
		.low_wait_sum(low_wait_sum), .high_occupancy(high_occupancy),
		.low_occupancy(low_occupancy),
		.reports_owed(reports_owed), .mismatches(mismatches)
	);

	// Report side: random stalls, plus a long hold whenever the stimulus asks for one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 0;
		end else if (hold_left != 0) begin
			res_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_done != hold_asked) begin
			res_ready <= 1'b0;
			hold_left <= LONG_HOLD;
			hold_done <= hold_asked;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Ends the run when nothing moves on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (res_valid && res_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	// Offers one tick request, after random idle cycles, and waits for its acceptance.
	task automatic offer_tick(logic [3:0] high_n, logic [3:0] low_n);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		high_requests <= high_n;
		low_requests <= low_n;
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	// Stops offering until every predicted report has been accepted, then lets the block settle.
	task automatic wait_reports_done();
		req_valid <= 1'b0;
		@(posedge clk);
		while (reports_owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write: setup cycle, access cycle, then a cycle with the bus released.
	// Upper data bits are random; only the low four bits belong to the register.
	task automatic write_capacity(logic reg_idx, logic [3:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= {28'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_capacities(logic [3:0] high_cap, logic [3:0] low_cap);
		write_capacity(REG_HIGH_CAP, high_cap);
		write_capacity(REG_LOW_CAP, low_cap);
	endtask

	initial begin
		logic [3:0] hn;
		logic [3:0] ln;
		int pick;
		int seg;
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset capacities: idle tick, both queues overflowing, drain through the high head.
		offer_tick(4'd0, 4'd0);
		offer_tick(4'd15, 4'd15);
		repeat (3) offer_tick(4'd0, 4'd0);
		offer_tick(4'd1, 4'd2);
		offer_tick(4'd0, 4'd0);
		wait_reports_done();

		// A zero capacity refuses everything; a capacity past the depth stops at the depth.
		set_capacities(4'd0, 4'd15);
		offer_tick(4'd15, 4'd15);
		repeat (2) offer_tick(4'd0, 4'd0);
		wait_reports_done();

		// Fill both queues completely, then shrink capacity below the current fill.
		set_capacities(4'd8, 4'd8);
		offer_tick(4'd15, 4'd15);
		wait_reports_done();
		set_capacities(4'd2, 4'd1);
		offer_tick(4'd3, 4'd3);
		offer_tick(4'd0, 4'd4);
		repeat (2) offer_tick(4'd0, 4'd0);
		offer_tick(4'd10, 4'd5);
		wait_reports_done();

		// Random segments, each under its own capacities and idling pattern.
		for (seg = 0; seg < SEGMENTS; seg++) begin
			set_capacities(HIGH_CAPS[seg], LOW_CAPS[seg]);
			if (seg < 4) begin
				send_idle_pct <= 31;
				recv_idle_pct <= 53;
			end else if (seg < 8) begin
				send_idle_pct <= 53;
				recv_idle_pct <= 31;
			end else begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
			end
			for (n = 0; n < SEGMENT_LEN; n++) begin
				// Long report stall while requests keep coming, so the input backs up.
				if (seg == 8 && n == 20)
					hold_asked <= hold_asked + 1;
				if (seg == 9 && n == 60)
					wait_reports_done();
				// Mostly light traffic so queues both fill and drain, some bursts.
				pick = $urandom_range(99);
				if (pick < 45) begin
					hn = ($urandom_range(3) == 0) ? 4'd1 : 4'd0;
					ln = ($urandom_range(2) == 0) ? 4'd1 : 4'd0;
				end else if (pick < 75) begin
					hn = 4'($urandom_range(2));
					ln = 4'($urandom_range(2));
				end else if (pick < 90) begin
					hn = 4'd0;
					ln = 4'd0;
				end else begin
					hn = 4'($urandom_range(15));
					ln = 4'($urandom_range(15));
				end
				offer_tick(hn, ln);
			end
			wait_reports_done();
		end

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
